// File: rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

  // trigger sequence lengths in ticks
  localparam int unsigned TrigLowTicks  = 4;
  localparam int unsigned TrigHighTicks = 10;

  // counter widths
  localparam int unsigned CntW   = 20;
  localparam int unsigned DistW  = 14;
  localparam int unsigned LimitW = 18;
  // dividend is the pulse width (bounded by the range limit) times 16
  localparam int unsigned DivW   = LimitW + 4;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // register reset values
  localparam logic [7:0] UsPerCmRst   = 8'd58;
  localparam logic [9:0] MaxDistCmRst = 10'd400;
  localparam logic [9:0] TimeoutMsRst = 10'd30;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_US_PER_CM   = 2'd0,
    REG_MAX_DIST_CM = 2'd1,
    REG_TIMEOUT_MS  = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // measurement phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TLOW  = 4'b0010,
    PH_THIGH = 4'b0100,
    PH_WAIT  = 4'b1000
  } phase_t;

  // outcome codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_BAD     = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // control sequencer, one-hot
  typedef enum logic [2:0] {
    CT_IDLE = 3'b001,
    CT_DIV  = 3'b010,
    CT_HOLD = 3'b100
  } ctrl_t;

  // one result item
  typedef struct packed {
    logic [DistW-1:0] distance_q4;
    status_t          status;
    logic             valid_res;
    logic             done_res;
    logic             busy_res;
    logic             trig_out;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger (trigger/echo style ranging sensor controller).
// Input stream: one transaction per microsecond tick, in_tdata carries the
// start request and the sampled echo pin level. Every input transaction gives
// exactly one output transaction with the trigger drive level, busy/done
// flags, the outcome code and the distance in 1/16 cm.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// us_per_cm (0), max_dist_cm (1) or timeout_ms (2); other indexes are ignored.
// Write registers only while no measurement is running.
// Flow: an accepted tick's result is staged in a register and then moved into
// the output register. On the tick that finishes a valid measurement the
// distance is first computed by a restoring divider that retires one quotient
// bit per cycle, and the staged result moves on to the output register after
// the last quotient bit.
// in_tready is high only while the sequencer is idle, one tick in flight.
// When the receiver stalls (out_tready low) the result waits in the output
// register and the sequencer holds the next result back; no data is lost.
// Reset (rst_n low, synchronous) restores register defaults and the idle
// phase; the output register empties.
`default_nettype none

module ultrasonic_echo_ranger_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input ticks
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] start_req, [1] echo_level, rest zero
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] trig_out, [1] busy_res, [2] done_res,
                                       // [3] valid_res, [5:4] status,
                                       // [19:6] distance_q4, rest zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // configuration registers
  logic [7:0] us_per_cm_r;
  logic [9:0] max_dist_cm_r;
  logic [9:0] timeout_ms_r;

  // measurement state
  uer_pkg::phase_t             phase_r, phase_nxt;
  logic [uer_pkg::CntW-1:0]    tick_cnt_r, tick_cnt_nxt;
  logic [uer_pkg::CntW-1:0]    pulse_w_r, pulse_w_nxt;
  logic                        rise_seen_r, rise_seen_nxt;
  logic                        last_echo_r;

  // sequencer and result staging
  uer_pkg::ctrl_t              ctrl_r;
  uer_pkg::result_t            res_r, res_nxt;
  uer_pkg::result_t            out_r;
  logic                        out_valid_r;
  logic                        need_div;
  logic [uer_pkg::LimitW-1:0]  dvd_nxt;

  // restoring divider
  logic [uer_pkg::DivW-1:0]    quo_r;
  logic [7:0]                  rem_r;
  logic [7:0]                  dvs_r;
  logic [uer_pkg::DivCntW-1:0] div_cnt_r;
  logic [8:0]                  rem_sh;
  logic [8:0]                  rem_sub;
  logic                        qbit;

  logic in_acc;
  logic out_free;
  logic start_req;
  logic echo_level;
  logic [uer_pkg::LimitW-1:0]  range_limit;
  logic [uer_pkg::CntW-1:0]    timeout_lim;

  assign start_req  = in_tdata[0];
  assign echo_level = in_tdata[1];

  assign in_tready  = (ctrl_r == uer_pkg::CT_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r};

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_per_cm_r   <= uer_pkg::UsPerCmRst;
      max_dist_cm_r <= uer_pkg::MaxDistCmRst;
      timeout_ms_r  <= uer_pkg::TimeoutMsRst;
    end else if (cfg_valid && cfg_ready) begin
      case (uer_pkg::reg_idx_t'(cfg_index))
        uer_pkg::REG_US_PER_CM:   us_per_cm_r   <= cfg_data[7:0];
        uer_pkg::REG_MAX_DIST_CM: max_dist_cm_r <= cfg_data;
        uer_pkg::REG_TIMEOUT_MS:  timeout_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // limits derived from the registers
  assign range_limit = uer_pkg::LimitW'(max_dist_cm_r) * uer_pkg::LimitW'(us_per_cm_r);
  assign timeout_lim = uer_pkg::CntW'(timeout_ms_r) * uer_pkg::CntW'(1000);

  // one tick of the measurement state machine
  always_comb begin
    phase_nxt     = phase_r;
    tick_cnt_nxt  = tick_cnt_r;
    pulse_w_nxt   = pulse_w_r;
    rise_seen_nxt = rise_seen_r;
    res_nxt       = '0;
    res_nxt.status = uer_pkg::ST_OK;
    need_div      = 1'b0;
    dvd_nxt       = '0;

    // start only from idle
    if (phase_r == uer_pkg::PH_IDLE && start_req) begin
      phase_nxt     = uer_pkg::PH_TLOW;
      tick_cnt_nxt  = '0;
      pulse_w_nxt   = '0;
      rise_seen_nxt = 1'b0;
    end

    case (phase_nxt)
      uer_pkg::PH_TLOW: begin
        res_nxt.busy_res = 1'b1;
        tick_cnt_nxt = tick_cnt_nxt + 1'b1;
        if (tick_cnt_nxt >= uer_pkg::CntW'(uer_pkg::TrigLowTicks)) begin
          phase_nxt    = uer_pkg::PH_THIGH;
          tick_cnt_nxt = '0;
        end
      end
      uer_pkg::PH_THIGH: begin
        res_nxt.busy_res = 1'b1;
        res_nxt.trig_out = 1'b1;
        tick_cnt_nxt = tick_cnt_nxt + 1'b1;
        if (tick_cnt_nxt >= uer_pkg::CntW'(uer_pkg::TrigHighTicks)) begin
          phase_nxt    = uer_pkg::PH_WAIT;
          tick_cnt_nxt = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        res_nxt.busy_res = 1'b1;
        // pulse width, restarted on a rising edge
        if (echo_level && !last_echo_r) begin
          rise_seen_nxt = 1'b1;
          pulse_w_nxt   = uer_pkg::CntW'(1);
        end else if (echo_level && pulse_w_nxt != uer_pkg::CntMax) begin
          pulse_w_nxt = pulse_w_nxt + 1'b1;
        end
        // falling edge wins over the timeout
        if (!echo_level && last_echo_r) begin
          res_nxt.done_res = 1'b1;
          if (!rise_seen_nxt || pulse_w_nxt == '0) begin
            res_nxt.status = uer_pkg::ST_BAD;
          end else if (pulse_w_nxt > uer_pkg::CntW'(range_limit)) begin
            res_nxt.status = uer_pkg::ST_RANGE;
          end else begin
            res_nxt.valid_res = 1'b1;
            need_div = 1'b1;
            // width is within the range limit here, so it fits the dividend
            dvd_nxt  = pulse_w_nxt[uer_pkg::LimitW-1:0];
          end
        end else begin
          if (tick_cnt_nxt != uer_pkg::CntMax) begin
            tick_cnt_nxt = tick_cnt_nxt + 1'b1;
          end
          if (tick_cnt_nxt >= timeout_lim) begin
            res_nxt.done_res = 1'b1;
            res_nxt.status   = uer_pkg::ST_TIMEOUT;
          end
        end
        if (res_nxt.done_res) begin
          phase_nxt     = uer_pkg::PH_IDLE;
          tick_cnt_nxt  = '0;
          pulse_w_nxt   = '0;
          rise_seen_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // measurement state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= uer_pkg::PH_IDLE;
      tick_cnt_r  <= '0;
      pulse_w_r   <= '0;
      rise_seen_r <= 1'b0;
      last_echo_r <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      pulse_w_r   <= pulse_w_nxt;
      rise_seen_r <= rise_seen_nxt;
      last_echo_r <= echo_level;
    end
  end

  // one restoring divide step
  assign rem_sh  = {rem_r, quo_r[uer_pkg::DivW-1]};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  // sequencer: take tick, divide if needed, hand result to output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= uer_pkg::CT_IDLE;
    end else begin
      case (ctrl_r)
        uer_pkg::CT_IDLE: begin
          if (in_acc) begin
            ctrl_r <= need_div ? uer_pkg::CT_DIV : uer_pkg::CT_HOLD;
          end
        end
        uer_pkg::CT_DIV: begin
          if (div_cnt_r == '0) begin
            ctrl_r <= uer_pkg::CT_HOLD;
          end
        end
        uer_pkg::CT_HOLD: begin
          if (out_free) begin
            ctrl_r <= uer_pkg::CT_IDLE;
          end
        end
        default: ctrl_r <= uer_pkg::CT_IDLE;
      endcase
    end
  end

  // divider datapath and result staging
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r     <= res_nxt;
      quo_r     <= {dvd_nxt, 4'b0000};
      rem_r     <= '0;
      dvs_r     <= us_per_cm_r;
      div_cnt_r <= uer_pkg::DivCntW'(uer_pkg::DivW - 1);
    end else if (ctrl_r == uer_pkg::CT_DIV) begin
      quo_r     <= {quo_r[uer_pkg::DivW-2:0], qbit};
      rem_r     <= rem_sub[7:0];
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == '0) begin
        res_r.distance_q4 <= {quo_r[uer_pkg::DistW-2:0], qbit};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_r == uer_pkg::CT_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_r == uer_pkg::CT_HOLD && out_free) begin
      out_r <= res_r;
    end
  end

  // a valid distance only comes with an ok outcome on a done tick
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.valid_res |-> out_r.done_res && out_r.status == uer_pkg::ST_OK)
    else $error("valid result without ok done");

  // distance is zero unless the result is valid
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.valid_res |-> out_r.distance_q4 == '0)
    else $error("distance set on non-valid result");

  // the last divide step always moves on to the hold state
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r == uer_pkg::CT_DIV && div_cnt_r == '0 |=> ctrl_r == uer_pkg::CT_HOLD)
    else $error("divider did not finish");

  // trigger high only while busy
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.trig_out |-> out_r.busy_res && !out_r.done_res)
    else $error("trigger driven outside measurement");

  // one tick in flight: no new transaction right after one is taken
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second tick taken while busy");

endmodule

`default_nettype wire
